FILE: design/http_request_line_parser_assert.svh
// assertion macros for the request line parser
// used by http_request_line_parser.sv, no other dependencies
`ifndef HTTP_REQUEST_LINE_PARSER_ASSERT_SVH
`define HTTP_REQUEST_LINE_PARSER_ASSERT_SVH

// check a property on every rising clock edge outside reset
`define HRLP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check that a condition on the accepted item shows in the next cycle
`define HRLP_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: design/hrlp_pkg.sv
// package for the request line parser: method codes, name table, helpers
// no dependencies
package hrlp_pkg;

   localparam int POS_BITS    = 16;
   localparam int NUM_METHODS = 9;
   localparam int MAX_LEN     = 7;
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   typedef logic [POS_BITS-1:0] pos_type;
   typedef logic [NUM_METHODS-1:0] cand_type;

   typedef enum logic [3:0] {
      M_GET     = 4'd0,
      M_HEAD    = 4'd1,
      M_POST    = 4'd2,
      M_PUT     = 4'd3,
      M_DELETE  = 4'd4,
      M_CONNECT = 4'd5,
      M_OPTIONS = 4'd6,
      M_TRACE   = 4'd7,
      M_PATCH   = 4'd8,
      M_UNKNOWN = 4'd9
   } method_type;

   // method names by code, padded with zero bytes
   localparam logic [7:0] METHOD_NAME [NUM_METHODS][MAX_LEN] = '{
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00},
      '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"D", "E", "L", "E", "T", "E", 8'h00},
      '{"C", "O", "N", "N", "E", "C", "T"},
      '{"O", "P", "T", "I", "O", "N", "S"},
      '{"T", "R", "A", "C", "E", 8'h00, 8'h00},
      '{"P", "A", "T", "C", "H", 8'h00, 8'h00}
   };

   localparam logic [2:0] METHOD_LEN [NUM_METHODS] = '{
      3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7, 3'd7, 3'd5, 3'd5
   };

   // position step that holds at all ones
   function automatic pos_type sat_inc(input pos_type v);
      return (v == '1) ? v : v + pos_type'(1);
   endfunction

   // clamp a position to the 16 bit result fields
   function automatic logic [15:0] sat16(input pos_type v);
      logic [47:0] w;
      w = 48'(v);
      return (w > 48'h0000_0000_FFFF) ? 16'hFFFF : w[15:0];
   endfunction

endpackage

FILE: design/http_request_line_parser.sv
// request line parser top level: method match, uri offset and length
// depends on hrlp_pkg and http_request_line_parser_assert.svh
//
//   channel  direction  handshake             payload
//   req      in         req_valid / req_stall data_byte, last_byte
//   rsp      out        rsp_valid / rsp_stall method_code, method_seen, uri_offset,
//                                             uri_length, complete
//
// one byte is taken every cycle while req_stall is low; a result shows in rsp in the cycle after the byte
// that causes it, loaded straight from that byte and the parse state into the result register
// reset clears the parse state and the result valid; no clearing pass
// input is stalled only while a result waits and the output side stalls
// after the final byte of a message the parse state returns to its reset values

`include "http_request_line_parser_assert.svh"

module http_request_line_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_method_code,
   output logic        rsp_method_seen,
   output logic [15:0] rsp_uri_offset,
   output logic [15:0] rsp_uri_length,
   output logic        rsp_complete
);

   // parse state
   hrlp_pkg::pos_type    pos_ff, pos_in;
   logic [1:0]           spaces_ff, spaces_in;
   hrlp_pkg::cand_type   cand_ff, cand_in;
   hrlp_pkg::method_type method_ff, method_in;
   hrlp_pkg::pos_type    uri_ff, uri_in;
   logic                 sent_ff, sent_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   hrlp_pkg::method_type out_method_ff, out_method_in;
   logic                 out_seen_ff, out_seen_in;
   logic [15:0]          out_offset_ff, out_offset_in;
   logic [15:0]          out_length_ff, out_length_in;
   logic                 out_complete_ff, out_complete_in;

   logic                 accept;
   logic                 emit;
   logic                 is_space;
   hrlp_pkg::method_type picked;
   hrlp_pkg::cand_type   narrowed;
   hrlp_pkg::pos_type    end_pos;
   hrlp_pkg::pos_type    len_full;

   assign req_stall = out_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign is_space  = (req_data_byte == hrlp_pkg::SPACE_CHAR);

   // drop candidates whose name does not have this byte at this position
   always_comb begin
      narrowed = cand_ff;
      for (int m = 0; m < hrlp_pkg::NUM_METHODS; m++) begin
         if (pos_ff >= hrlp_pkg::pos_type'(hrlp_pkg::METHOD_LEN[m])) begin
            narrowed[m] = 1'b0;
         end else if (hrlp_pkg::METHOD_NAME[m][pos_ff[2:0]] != req_data_byte) begin
            narrowed[m] = 1'b0;
         end
      end
   end

   // lowest code among surviving candidates of the token's length
   always_comb begin
      picked = hrlp_pkg::M_UNKNOWN;
      for (int m = hrlp_pkg::NUM_METHODS - 1; m >= 0; m--) begin
         if (cand_ff[m] && pos_ff == hrlp_pkg::pos_type'(hrlp_pkg::METHOD_LEN[m])) begin
            picked = hrlp_pkg::method_type'(4'(m));
         end
      end
   end

   // next parse state and result for the accepted item
   always_comb begin
      pos_in          = pos_ff;
      spaces_in       = spaces_ff;
      cand_in         = cand_ff;
      method_in       = method_ff;
      uri_in          = uri_ff;
      sent_in         = sent_ff;
      emit            = 1'b0;
      end_pos         = hrlp_pkg::sat_inc(pos_ff);
      len_full        = '0;
      out_method_in   = out_method_ff;
      out_seen_in     = out_seen_ff;
      out_offset_in   = out_offset_ff;
      out_length_in   = out_length_ff;
      out_complete_in = out_complete_ff;

      if (accept) begin
         if (!sent_ff) begin
            if (is_space) begin
               if (spaces_ff == 2'd0) begin
                  method_in = picked;
                  uri_in    = hrlp_pkg::sat_inc(pos_ff);
                  spaces_in = 2'd1;
               end else begin
                  // second space: full result
                  len_full        = (pos_ff >= uri_ff) ? pos_ff - uri_ff : '0;
                  emit            = 1'b1;
                  out_method_in   = method_ff;
                  out_seen_in     = 1'b1;
                  out_offset_in   = hrlp_pkg::sat16(uri_ff);
                  out_length_in   = hrlp_pkg::sat16(len_full);
                  out_complete_in = 1'b1;
                  spaces_in       = 2'd2;
                  sent_in         = 1'b1;
               end
            end else if (spaces_ff == 2'd0) begin
               cand_in = narrowed;
            end

            // message ended before a second space
            if (req_last_byte && !emit) begin
               emit            = 1'b1;
               out_complete_in = 1'b0;
               if (spaces_in == 2'd1) begin
                  len_full      = (end_pos >= uri_in) ? end_pos - uri_in : '0;
                  out_method_in = method_in;
                  out_seen_in   = 1'b1;
                  out_offset_in = hrlp_pkg::sat16(uri_in);
                  out_length_in = hrlp_pkg::sat16(len_full);
               end else begin
                  out_method_in = hrlp_pkg::M_UNKNOWN;
                  out_seen_in   = 1'b0;
                  out_offset_in = '0;
                  out_length_in = '0;
               end
            end
         end

         pos_in = end_pos;
         if (req_last_byte) begin
            pos_in    = '0;
            spaces_in = 2'd0;
            cand_in   = '1;
            method_in = hrlp_pkg::M_UNKNOWN;
            uri_in    = '0;
            sent_in   = 1'b0;
         end
      end

      // result valid: load on a new result, drop when taken
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control and parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         spaces_ff    <= 2'd0;
         cand_ff      <= '1;
         method_ff    <= hrlp_pkg::M_UNKNOWN;
         uri_ff       <= '0;
         sent_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         spaces_ff    <= spaces_in;
         cand_ff      <= cand_in;
         method_ff    <= method_in;
         uri_ff       <= uri_in;
         sent_ff      <= sent_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      out_method_ff   <= out_method_in;
      out_seen_ff     <= out_seen_in;
      out_offset_ff   <= out_offset_in;
      out_length_ff   <= out_length_in;
      out_complete_ff <= out_complete_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_method_code = out_method_ff;
   assign rsp_method_seen = out_seen_ff;
   assign rsp_uri_offset  = out_offset_ff;
   assign rsp_uri_length  = out_length_ff;
   assign rsp_complete    = out_complete_ff;

   // checks
   `HRLP_ASSERT(a_complete_needs_method, !(out_valid_ff && out_complete_ff) || out_seen_ff, "complete result without a first space")
   `HRLP_ASSERT(a_no_method_fields, !(out_valid_ff && !out_seen_ff) || (out_method_ff == hrlp_pkg::M_UNKNOWN && out_offset_ff == 16'd0 && out_length_ff == 16'd0 && !out_complete_ff), "result without method carries nonzero fields")
   `HRLP_ASSERT(a_sent_means_two_spaces, !sent_ff || spaces_ff == 2'd2, "result sent but space count is not two")
   `HRLP_ASSERT(a_stall_only_when_full, !req_stall || out_valid_ff, "input stalled with empty result register")
   `HRLP_ASSERT_NEXT(a_reset_after_last, accept && req_last_byte, pos_ff == '0 && spaces_ff == 2'd0 && !sent_ff && cand_ff == '1, "state not cleared after final byte")

endmodule

FILE: tb/tb_top.sv
// testbench for http_request_line_parser: request bytes in, parsed line summaries out
// depends on hrlp_pkg for the method codes and position type; self-checking, no files
`timescale 1ns / 100ps

module tb_top;

   // method spelling table: start in name_chars and length, by method code
   localparam int NAME_START [hrlp_pkg::NUM_METHODS] = '{0, 10, 6, 3, 24, 37, 30, 19, 14};
   localparam int NAME_LEN   [hrlp_pkg::NUM_METHODS] = '{3, 4, 4, 3, 6, 7, 7, 5, 5};
   localparam int IDLE_SEND  [4] = '{0, 52, 0, 7};
   localparam int IDLE_RECV  [4] = '{0, 0, 52, 7};

   typedef logic [7:0] octet_queue_type [$];

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       hold;
   } byte_item_type;

   typedef struct packed {
      hrlp_pkg::method_type method;
      logic                 seen;
      logic [15:0]          offset;
      logic [15:0]          length;
      logic                 complete;
   } line_summary_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_method_code;
   logic        rsp_method_seen;
   logic [15:0] rsp_uri_offset;
   logic [15:0] rsp_uri_length;
   logic        rsp_complete;

   byte_item_type    pending_bytes [$];
   line_summary_type expected_lines [$];
   int               send_idle = 0;
   int               recv_stall = 0;
   int               mismatches = 0;
   string            name_chars;

   // parse state of the predictor
   hrlp_pkg::pos_type    msg_pos;
   logic [1:0]           spaces_seen;
   hrlp_pkg::cand_type   live_methods;
   hrlp_pkg::method_type parsed_method;
   hrlp_pkg::pos_type    uri_begin;
   logic                 line_done;

   http_request_line_parser i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_method_code (rsp_method_code),
      .rsp_method_seen (rsp_method_seen),
      .rsp_uri_offset  (rsp_uri_offset),
      .rsp_uri_length  (rsp_uri_length),
      .rsp_complete    (rsp_complete)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic note_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   function automatic hrlp_pkg::pos_type pos_next(input hrlp_pkg::pos_type v);
      return (v == '1) ? v : v + hrlp_pkg::pos_type'(1);
   endfunction

   function automatic logic [15:0] clamp16(input hrlp_pkg::pos_type v);
      return (64'(v) > 64'hFFFF) ? 16'hFFFF : 16'(v);
   endfunction

   task automatic clear_parse();
      msg_pos       = '0;
      spaces_seen   = 2'd0;
      live_methods  = '1;
      parsed_method = hrlp_pkg::M_UNKNOWN;
      uri_begin     = '0;
      line_done     = 1'b0;
   endtask

   // drop every method whose spelling disagrees at this position
   task automatic narrow_methods(input hrlp_pkg::pos_type here, input logic [7:0] data);
      for (int m = 0; m < hrlp_pkg::NUM_METHODS; m++) begin
         if (!(here < NAME_LEN[m] && name_chars[NAME_START[m] + here] == data))
            live_methods[m] = 1'b0;
      end
   endtask

   function automatic hrlp_pkg::method_type choose_method(input hrlp_pkg::pos_type token_len);
      for (int m = 0; m < hrlp_pkg::NUM_METHODS; m++) begin
         if (live_methods[m] && NAME_LEN[m] == token_len) return hrlp_pkg::method_type'(m);
      end
      return hrlp_pkg::M_UNKNOWN;
   endfunction

   // advance the parse by one accepted byte, queue the summary it causes
   task automatic parse_byte(input logic [7:0] data, input logic last);
      hrlp_pkg::pos_type here;
      hrlp_pkg::pos_type end_pos;
      line_summary_type  got;
      logic              made;
      here = msg_pos;
      made = 1'b0;
      got  = '0;
      if (!line_done) begin
         if (data == hrlp_pkg::SPACE_CHAR) begin
            if (spaces_seen == 2'd0) begin
               parsed_method = choose_method(here);
               uri_begin     = pos_next(here);
               spaces_seen   = 2'd1;
            end else begin
               got.method   = parsed_method;
               got.seen     = 1'b1;
               got.offset   = clamp16(uri_begin);
               got.length   = clamp16((here >= uri_begin) ? here - uri_begin : '0);
               got.complete = 1'b1;
               made         = 1'b1;
               spaces_seen  = 2'd2;
               line_done    = 1'b1;
            end
         end else if (spaces_seen == 2'd0) begin
            narrow_methods(here, data);
         end
         // message ended before the second space
         if (last && !made) begin
            if (spaces_seen == 2'd1) begin
               end_pos    = pos_next(here);
               got.method = parsed_method;
               got.seen   = 1'b1;
               got.offset = clamp16(uri_begin);
               got.length = clamp16((end_pos >= uri_begin) ? end_pos - uri_begin : '0);
            end else begin
               got.method = hrlp_pkg::M_UNKNOWN;
            end
            got.complete = 1'b0;
            made         = 1'b1;
         end
         if (made) expected_lines.push_back(got);
      end
      msg_pos = pos_next(here);
      if (last) clear_parse();
   endtask

   task automatic check_line();
      line_summary_type want;
      if (expected_lines.size() == 0) begin
         note_mismatch("result with nothing expected");
         return;
      end
      want = expected_lines.pop_front();
      if (rsp_method_code !== want.method)
         note_mismatch($sformatf("method_code %0d, want %0d", rsp_method_code, want.method));
      if (rsp_method_seen !== want.seen)
         note_mismatch($sformatf("method_seen %0b, want %0b", rsp_method_seen, want.seen));
      if (rsp_uri_offset !== want.offset)
         note_mismatch($sformatf("uri_offset %0d, want %0d", rsp_uri_offset, want.offset));
      if (rsp_uri_length !== want.length)
         note_mismatch($sformatf("uri_length %0d, want %0d", rsp_uri_length, want.length));
      if (rsp_complete !== want.complete)
         note_mismatch($sformatf("complete %0b, want %0b", rsp_complete, want.complete));
   endtask

   // byte driver: predict on accept, then present the next pending item or idle
   always @(posedge clock) begin : drive_bytes
      byte_item_type nxt;
      if (reset) begin
         req_valid     <= 1'b0;
         req_data_byte <= 8'h00;
         req_last_byte <= 1'b0;
      end else begin
         if (req_valid && !req_stall) parse_byte(req_data_byte, req_last_byte);
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0
                && !(pending_bytes[0].hold && expected_lines.size() != 0)
                && $urandom_range(99) >= send_idle) begin
               nxt = pending_bytes.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= nxt.data;
               req_last_byte <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin : watch_lines
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_line();
         rsp_stall <= ($urandom_range(99) < recv_stall);
      end
   end

   function automatic logic [7:0] any_but_space();
      logic [7:0] v;
      do v = 8'($urandom_range(255)); while (v == hrlp_pkg::SPACE_CHAR);
      return v;
   endfunction

   task automatic append_text(ref octet_queue_type msg, input string s);
      for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
   endtask

   // one message into the pending items, final flag on its last byte
   task automatic queue_msg(input octet_queue_type msg, input logic hold);
      byte_item_type it;
      foreach (msg[i]) begin
         it.data = msg[i];
         it.last = (i == msg.size() - 1);
         it.hold = hold && (i == 0);
         pending_bytes.push_back(it);
      end
   endtask

   // random request: mostly well formed lines, some cut short, some noise
   task automatic build_request(ref octet_queue_type msg, output int useful);
      int              kind;
      int              pick;
      int              m;
      int              n;
      int              spot;
      octet_queue_type token;
      msg.delete();
      kind = $urandom_range(99);
      pick = $urandom_range(11);
      m    = $urandom_range(hrlp_pkg::NUM_METHODS - 1);
      if (pick == 9) begin
         n = $urandom_range(8);
         repeat (n) token.push_back(any_but_space());
      end else begin
         for (int i = 0; i < NAME_LEN[m]; i++) token.push_back(name_chars[NAME_START[m] + i]);
         // misspelled by one bit, or one byte short or long
         if (pick == 10) begin
            spot = $urandom_range(NAME_LEN[m] - 1);
            token[spot] = token[spot] ^ 8'(1 << $urandom_range(7));
         end else if (pick == 11) begin
            if ($urandom_range(1)) void'(token.pop_back());
            else token.push_back("S");
         end
      end
      foreach (token[i]) msg.push_back(token[i]);
      if (kind < 80) begin
         msg.push_back(hrlp_pkg::SPACE_CHAR);
         n = $urandom_range(kind < 70 ? 10 : 6);
         repeat (n) msg.push_back(any_but_space());
         if (kind < 70) msg.push_back(hrlp_pkg::SPACE_CHAR);
         useful = msg.size();
         if (kind < 70) repeat ($urandom_range(4)) msg.push_back(8'($urandom_range(255)));
      end else if (kind < 90) begin
         if (msg.size() == 0) msg.push_back(any_but_space());
         useful = msg.size();
      end else begin
         msg.delete();
         n = $urandom_range(1, 12);
         repeat (n) msg.push_back(($urandom_range(2) == 0) ? hrlp_pkg::SPACE_CHAR
                                                           : 8'($urandom_range(255)));
         useful = n;
      end
   endtask

   initial begin : stimulus
      octet_queue_type msg;
      int              fed;
      int              useful;
      logic            first;
      name_chars = "GETPUTPOSTHEADPATCHTRACEDELETEOPTIONSCONNECT";
      clear_parse();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 4; p++) begin
         @(negedge clock);
         send_idle  = IDLE_SEND[p];
         recv_stall = IDLE_RECV[p];
         if (p == 0) begin
            // message ends without any space, on a zero byte
            msg.delete(); msg.push_back(8'h00); queue_msg(msg, 1'b0);
            // first space is the final byte
            msg.delete(); append_text(msg, " "); queue_msg(msg, 1'b0);
            // second space on the final byte, empty uri
            msg.delete(); append_text(msg, "GET  "); queue_msg(msg, 1'b0);
            // ends after the first space, uri ends on an all-ones byte
            msg.delete(); append_text(msg, "PUT /"); msg.push_back(8'hFF); queue_msg(msg, 1'b0);
            // misspelled and overlong tokens, bytes after the second space
            msg.delete(); append_text(msg, "GEX /a b"); queue_msg(msg, 1'b0);
            msg.delete(); append_text(msg, "POSTS / "); queue_msg(msg, 1'b0);
            // every method, ended by its first space
            for (int m = 0; m < hrlp_pkg::NUM_METHODS; m++) begin
               msg.delete();
               for (int i = 0; i < NAME_LEN[m]; i++) msg.push_back(name_chars[NAME_START[m] + i]);
               msg.push_back(hrlp_pkg::SPACE_CHAR);
               queue_msg(msg, 1'b0);
            end
         end
         fed   = 0;
         first = 1'b1;
         while (fed < 125) begin
            build_request(msg, useful);
            queue_msg(msg, first || ($urandom_range(19) == 0));
            first = 1'b0;
            fed  += useful;
         end
         do @(negedge clock);
         while (pending_bytes.size() != 0 || req_valid || expected_lines.size() != 0);
      end

      // let any stray result surface
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_lines.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/hrlp_pkg.sv
design/http_request_line_parser.sv
tb/tb_top.sv
